// File: rtl/sns_pkg.sv
// Shared types and constants for the storage node selector.
// Used by the controller, the datapath and the top level; no dependencies.
package sns_pkg;

  localparam int CMD_W      = 3;
  localparam int NODE_IDX_W = 3;
  localparam int COUNT_W    = 16;
  localparam int LETTER_W   = 8;
  localparam int CHOSEN_W   = 3;
  localparam int STATUS_W   = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int LU_W       = 4;

  localparam logic [LU_W-1:0]            NONE_USED     = 4'd15;
  localparam logic signed [LETTER_W-1:0] LETTER_A      = 8'sd97;
  localparam logic signed [LETTER_W-1:0] LAST_LETTER   = 8'sd122;
  localparam logic signed [LETTER_W-1:0] NO_LETTER     = -8'sd1;
  localparam logic [COUNT_W-1:0]         ENTRY_RESET   = 16'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER = 3'd0,
    CMD_DOWN     = 3'd1,
    CMD_UP       = 3'd2,
    CMD_REPORT   = 3'd3,
    CMD_CHOOSE   = 3'd4
  } cmd_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FREE  = 2'd0,
    MODE_RR    = 2'd1,
    MODE_RANGE = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NO_UP = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIST_MODE  = 1'd0,
    CFG_GRANT_SIZE = 1'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_DECODE,
    OP_COUNT,
    OP_REWIND,
    OP_SPLIT,
    OP_FIXUP,
    OP_FREE,
    OP_RR,
    OP_RANGE,
    OP_LOAD
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [MODE_W-1:0] mode;
    logic              table_full;
    logic              bad_index;
    logic              any_up;
    logic              walk_done;
    logic              n_zero;
    logic              rr_hit;
  } dp_flags_t;

  // Letters per up node: 26 divided by the number of up nodes.
  function automatic logic [4:0] letters_per_node(input logic [4:0] n);
    logic [4:0] per;
    case (n)
      5'd1:    per = 5'd26;
      5'd2:    per = 5'd13;
      5'd3:    per = 5'd8;
      5'd4:    per = 5'd6;
      5'd5:    per = 5'd5;
      5'd6:    per = 5'd4;
      5'd7:    per = 5'd3;
      5'd8:    per = 5'd3;
      5'd9:    per = 5'd2;
      5'd10:   per = 5'd2;
      5'd11:   per = 5'd2;
      5'd12:   per = 5'd2;
      5'd13:   per = 5'd2;
      5'd14:   per = 5'd1;
      5'd15:   per = 5'd1;
      5'd16:   per = 5'd1;
      default: per = 5'd0;
    endcase
    return per;
  endfunction

endpackage

// File: rtl/sns_ctrl.sv
// Sequencer for the storage node selector: input and output handshakes and
// the order of datapath operations. Depends on sns_pkg.
module sns_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  sns_pkg::dp_flags_t flags,
  output sns_pkg::dp_cmd_t   dp_cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_COUNT,
    S_SPLIT,
    S_FREE,
    S_RR,
    S_RANGE,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next = state;
    dp_cmd.op  = sns_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.op  = sns_pkg::OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        dp_cmd.op  = sns_pkg::OP_DECODE;
        state_next = S_FINISH;
        case (flags.cmd)
          sns_pkg::CMD_REGISTER: if (!flags.table_full) state_next = S_COUNT;
          sns_pkg::CMD_DOWN:     if (!flags.bad_index) state_next = S_COUNT;
          sns_pkg::CMD_CHOOSE: begin
            if (flags.any_up) begin
              case (flags.mode)
                sns_pkg::MODE_FREE:  state_next = S_FREE;
                sns_pkg::MODE_RR:    state_next = S_RR;
                sns_pkg::MODE_RANGE: state_next = S_RANGE;
                default:             state_next = S_FINISH;
              endcase
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_COUNT: begin
        if (flags.walk_done) begin
          dp_cmd.op  = sns_pkg::OP_REWIND;
          state_next = flags.n_zero ? S_FINISH : S_SPLIT;
        end else begin
          dp_cmd.op = sns_pkg::OP_COUNT;
        end
      end
      S_SPLIT: begin
        if (flags.walk_done) begin
          dp_cmd.op  = sns_pkg::OP_FIXUP;
          state_next = S_FINISH;
        end else begin
          dp_cmd.op = sns_pkg::OP_SPLIT;
        end
      end
      S_FREE: begin
        if (flags.walk_done) state_next = S_FINISH;
        else dp_cmd.op = sns_pkg::OP_FREE;
      end
      S_RR: begin
        // At least one node is up, so the walk always ends on a hit.
        dp_cmd.op = sns_pkg::OP_RR;
        if (flags.rr_hit) state_next = S_FINISH;
      end
      S_RANGE: begin
        if (flags.walk_done) state_next = S_FINISH;
        else dp_cmd.op = sns_pkg::OP_RANGE;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          dp_cmd.op  = sns_pkg::OP_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (dp_cmd.op == sns_pkg::OP_LOAD) out_valid_next = 1'b1;
    else if (out_valid && !out_stall) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/sns_datapath.sv
// Node table, configuration registers, walk registers and result register
// of the storage node selector. Driven by sns_ctrl; depends on sns_pkg.
module sns_datapath #(
  parameter int MAX_NODES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sns_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sns_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [sns_pkg::CMD_W-1:0]            command,
  input  logic [sns_pkg::NODE_IDX_W-1:0]       node_index,
  input  logic [sns_pkg::COUNT_W-1:0]          free_count,
  input  logic signed [sns_pkg::LETTER_W-1:0]  key_letter,
  input  logic                                 simulate,
  input  sns_pkg::dp_cmd_t                     dp_cmd,
  output sns_pkg::dp_flags_t                   flags,
  output logic [sns_pkg::CHOSEN_W-1:0]         node_pick,
  output logic [sns_pkg::STATUS_W-1:0]         status
);

  localparam int IdxW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NcW  = $clog2(MAX_NODES + 1);
  localparam int CmpW = (NcW > sns_pkg::NODE_IDX_W) ? NcW : sns_pkg::NODE_IDX_W;
  localparam int PW   = (NcW > sns_pkg::LU_W + 1) ? NcW : sns_pkg::LU_W + 1;
  localparam int ChW  = sns_pkg::CHOSEN_W;
  localparam int LtW  = sns_pkg::LETTER_W;
  localparam int CtW  = sns_pkg::COUNT_W;
  localparam int LuW  = sns_pkg::LU_W;

  // Configuration and node table state that reset defines.
  logic [sns_pkg::MODE_W-1:0] dist_mode;
  logic [CtW-1:0]             grant_size;
  logic [NcW-1:0]             node_count;
  logic [MAX_NODES-1:0]       up_flags;
  logic [LuW-1:0]             last_used;

  // Per-node stores, written before they are read.
  logic [CtW-1:0]        free_slots   [MAX_NODES];
  logic signed [LtW-1:0] range_low    [MAX_NODES];
  logic signed [LtW-1:0] range_high   [MAX_NODES];

  // Latched input word.
  logic [sns_pkg::CMD_W-1:0]      cmd_q;
  logic [sns_pkg::NODE_IDX_W-1:0] idx_q;
  logic [CtW-1:0]                 fc_q;
  logic signed [LtW-1:0]          key_q;
  logic                           sim_q;

  // Walk registers.
  logic [NcW-1:0]        walk;
  logic [NcW-1:0]        n_up;
  logic signed [LtW-1:0] first;
  logic [CtW-1:0]        best_fe;
  logic                  found;
  logic [LuW-1:0]        rr_ptr;
  logic [ChW-1:0]        res_idx;
  sns_pkg::status_t      res_status;

  logic [IdxW-1:0]       walk_ix;
  logic [IdxW-1:0]       idx_ix;
  logic [IdxW-1:0]       nc_ix;
  logic [IdxW-1:0]       last_ix;
  logic                  up_i;
  logic [CtW-1:0]        fe_i;
  logic signed [LtW-1:0] lo_i;
  logic signed [LtW-1:0] hi_i;
  logic [4:0]            per;
  logic signed [LtW-1:0] per_s;
  logic                  wrap;
  logic [LuW-1:0]        rr_next;
  logic                  table_full;
  logic                  bad_index;

  assign walk_ix = IdxW'(walk);
  assign idx_ix  = IdxW'(idx_q);
  assign nc_ix   = IdxW'(node_count);
  assign last_ix = IdxW'(node_count - NcW'(1));
  assign up_i    = up_flags[walk_ix];
  assign fe_i    = free_slots[walk_ix];
  assign lo_i    = range_low[walk_ix];
  assign hi_i    = range_high[walk_ix];
  assign per     = sns_pkg::letters_per_node(5'(n_up));
  assign per_s   = $signed(LtW'(per));

  assign table_full = (node_count == NcW'(MAX_NODES));
  assign bad_index  = (CmpW'(idx_q) >= CmpW'(node_count));

  // Round robin step: wrap to node 0 from "none yet" or from the last node.
  assign wrap    = (rr_ptr == sns_pkg::NONE_USED) ||
                   ((PW'(rr_ptr) + PW'(1)) >= PW'(node_count));
  assign rr_next = wrap ? '0 : rr_ptr + LuW'(1);

  assign flags.cmd        = cmd_q;
  assign flags.mode       = dist_mode;
  assign flags.table_full = table_full;
  assign flags.bad_index  = bad_index;
  assign flags.any_up     = |up_flags;
  assign flags.walk_done  = (walk == node_count);
  assign flags.n_zero     = (n_up == '0);
  assign flags.rr_hit     = up_flags[IdxW'(rr_next)];

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_mode  <= sns_pkg::MODE_FREE;
      grant_size <= sns_pkg::ENTRY_RESET;
      node_count <= '0;
      up_flags   <= '0;
      last_used  <= sns_pkg::NONE_USED;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sns_pkg::CFG_DIST_MODE:  dist_mode <= cfg_data[sns_pkg::MODE_W-1:0];
          sns_pkg::CFG_GRANT_SIZE: grant_size <= cfg_data[CtW-1:0];
          default: ;
        endcase
      end
      case (dp_cmd.op)
        sns_pkg::OP_DECODE: begin
          case (cmd_q)
            sns_pkg::CMD_REGISTER: begin
              if (!table_full) begin
                up_flags[nc_ix] <= 1'b1;
                node_count      <= node_count + NcW'(1);
              end
            end
            sns_pkg::CMD_DOWN: if (!bad_index) up_flags[idx_ix] <= 1'b0;
            sns_pkg::CMD_UP:   if (!bad_index) up_flags[idx_ix] <= 1'b1;
            default: ;
          endcase
        end
        sns_pkg::OP_RR: begin
          if (flags.rr_hit && !sim_q) last_used <= rr_next;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (dp_cmd.op)
      sns_pkg::OP_LATCH: begin
        cmd_q <= command;
        idx_q <= node_index;
        fc_q  <= free_count;
        key_q <= key_letter;
        sim_q <= simulate;
      end
      sns_pkg::OP_DECODE: begin
        walk    <= '0;
        n_up    <= '0;
        first   <= sns_pkg::LETTER_A;
        best_fe <= '0;
        found   <= 1'b0;
        rr_ptr  <= last_used;
        case (cmd_q)
          sns_pkg::CMD_REGISTER: begin
            if (table_full) begin
              res_idx    <= '0;
              res_status <= sns_pkg::ST_FULL;
            end else begin
              res_idx           <= ChW'(node_count);
              res_status        <= sns_pkg::ST_OK;
              free_slots[nc_ix] <= grant_size;
            end
          end
          sns_pkg::CMD_DOWN, sns_pkg::CMD_UP, sns_pkg::CMD_REPORT: begin
            res_idx    <= ChW'(idx_q);
            res_status <= bad_index ? sns_pkg::ST_BAD : sns_pkg::ST_OK;
            if (!bad_index && cmd_q == sns_pkg::CMD_REPORT) free_slots[idx_ix] <= fc_q;
          end
          sns_pkg::CMD_CHOOSE: begin
            res_idx    <= '0;
            res_status <= (|up_flags) ? sns_pkg::ST_OK : sns_pkg::ST_NO_UP;
          end
          default: begin
            res_idx    <= '0;
            res_status <= sns_pkg::ST_OK;
          end
        endcase
      end
      sns_pkg::OP_COUNT: begin
        if (up_i) n_up <= n_up + NcW'(1);
        walk <= walk + NcW'(1);
      end
      sns_pkg::OP_REWIND: walk <= '0;
      sns_pkg::OP_SPLIT: begin
        if (up_i) begin
          range_low[walk_ix]  <= first;
          range_high[walk_ix] <= first + per_s;
          first               <= first + per_s;
        end else begin
          range_low[walk_ix]  <= sns_pkg::NO_LETTER;
          range_high[walk_ix] <= sns_pkg::NO_LETTER;
        end
        walk <= walk + NcW'(1);
      end
      sns_pkg::OP_FIXUP: begin
        // The highest registered node stretches to 'z', even when it is down.
        if (first < sns_pkg::LAST_LETTER) range_high[last_ix] <= sns_pkg::LAST_LETTER;
      end
      sns_pkg::OP_FREE: begin
        if (up_i && (!found || fe_i > best_fe)) begin
          res_idx <= ChW'(walk);
          best_fe <= fe_i;
          found   <= 1'b1;
        end
        walk <= walk + NcW'(1);
      end
      sns_pkg::OP_RR: begin
        rr_ptr <= rr_next;
        if (flags.rr_hit) res_idx <= ChW'(rr_next);
      end
      sns_pkg::OP_RANGE: begin
        // Later matches overwrite earlier ones.
        if (key_q >= lo_i && key_q <= hi_i) res_idx <= ChW'(walk);
        walk <= walk + NcW'(1);
      end
      sns_pkg::OP_LOAD: begin
        node_pick <= res_idx;
        status    <= res_status;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/storage_node_selector.sv
// Top level of the storage node selector: joins the sequencer and the
// datapath. Depends on sns_pkg, sns_ctrl and sns_datapath.
//
// Usage: one command word enters on the input channel (command, node_index,
// free_count, key_letter, simulate) when in_valid is high and in_stall low.
// Each word gives exactly one result word (node_pick, status) on the
// output channel, taken when out_valid is high and out_stall low.
// Words are handled one at a time. After a word is latched and decoded:
//   mark up, report free, errors and unknown commands go straight to the
//   result; choose walks the registered nodes once (round robin steps
//   from the last used node to the next up node); register and mark down
//   walk the table once to count up nodes and once to split the letter
//   ranges (a mark down that leaves no node up skips the split walk).
// The next word can be taken in the cycle in which out_valid rises; the
// node walks handle one table entry per cycle. in_stall is high during
// reset and while a word is being worked on. A finished result sits in
// the output register, and the next word is accepted while it waits; if
// out_stall holds, the following result waits in the datapath until the
// register is free.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and are meant for idle periods. Reset empties the node table, sets
// round robin to "none yet", the mode to 0 and the grant size to 64.
module storage_node_selector #(
  parameter int MAX_NODES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sns_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sns_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sns_pkg::CMD_W-1:0]            command,
  input  logic [sns_pkg::NODE_IDX_W-1:0]       node_index,
  input  logic [sns_pkg::COUNT_W-1:0]          free_count,
  input  logic signed [sns_pkg::LETTER_W-1:0]  key_letter,
  input  logic                                 simulate,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sns_pkg::CHOSEN_W-1:0]         node_pick,
  output logic [sns_pkg::STATUS_W-1:0]         status
);

  sns_pkg::dp_cmd_t   dp_cmd;
  sns_pkg::dp_flags_t flags;

  sns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .dp_cmd    (dp_cmd)
  );

  sns_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .command    (command),
    .node_index (node_index),
    .free_count (free_count),
    .key_letter (key_letter),
    .simulate   (simulate),
    .dp_cmd     (dp_cmd),
    .flags      (flags),
    .node_pick  (node_pick),
    .status     (status)
  );

endmodule

// File: rtl/sns_checker.sv
// Port-level checks for storage_node_selector, attached with a bind.
// Sees only the top-level ports; depends on sns_pkg.
module sns_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [sns_pkg::CHOSEN_W-1:0] node_pick,
  input logic [sns_pkg::STATUS_W-1:0] status
);

  // A word once taken keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // A new result only appears after the block was busy with a word.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work");

  // No node up and table full both answer node 0.
  a_error_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == sns_pkg::ST_NO_UP || status == sns_pkg::ST_FULL))
      |-> (node_pick == '0))
    else $error("error result names a node");

  // A stalled result holds.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(node_pick) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind storage_node_selector sns_checker u_sns_checker (.*);
